// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/rsc_pkg.sv =====
// Package for the RTT-statistics congestion window block.
// Widths, reset values, codes, state encoding and the divide-by-three helpers.
package rsc_pkg;

   localparam int WIN_W      = 16;
   localparam int TIME_W     = 32;
   localparam int FRAC_W     = 8;
   localparam int MEAN_W     = TIME_W + FRAC_W;   // Q32.8
   localparam int SQ_W       = 64;
   localparam int CNT_W      = 32;
   localparam int CHUNK_W    = 20;                // multiplier A operand
   localparam int MUL_B_W    = 32;                // multiplier B operand
   localparam int MUL_P_W    = CHUNK_W + MUL_B_W; // 52
   localparam int SQPROD_W   = 2 * MEAN_W;        // 80
   localparam int ACC_W      = SQPROD_W + CNT_W;  // 112
   localparam int MUL_PARTS  = 4;
   localparam int STEP_W     = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [WIN_W-1:0]  INIT_WINDOW_RST = 16'd10;
   localparam logic [TIME_W-1:0] RTT_THRESH_RST  = 32'd130;
   localparam logic [WIN_W-1:0]  WINDOW_MAX      = 16'hFFFF;
   localparam logic [CNT_W-1:0]  COUNT_MAX       = 32'hFFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_WINDOW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RTT_THRESHOLD  = 2'd1;

   localparam logic MODE_ACK     = 1'b0;
   localparam logic MODE_TIMEOUT = 1'b1;

   typedef struct packed {
      logic              mode;
      logic [TIME_W-1:0] rtt;
   } rsc_item_type;

   typedef struct packed {
      logic             en;
      logic [WIN_W-1:0] value;
   } rsc_wload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MEAN,
      ST_MULA,
      ST_SQ,
      ST_MULB,
      ST_PSAVE,
      ST_MULC,
      ST_ADJ,
      ST_FIN
   } rsc_state_type;

   // floor(w/3) by reciprocal multiply, exact over 16 bits
   function automatic logic [WIN_W-1:0] div3(input logic [WIN_W-1:0] w);
      logic [2*WIN_W-1:0] p;
      p = {16'd0, w} * 32'h0000_AAAB;
      return {1'b0, p[31:17]};
   endfunction

   // floor(2w/3) = 2*floor(w/3) + (w mod 3 == 2)
   function automatic logic [WIN_W-1:0] two_thirds(input logic [WIN_W-1:0] w);
      logic [WIN_W-1:0] q;
      logic [WIN_W-1:0] r;
      q = div3(w);
      r = w - (q + {q[WIN_W-2:0], 1'b0});
      return {q[WIN_W-2:0], 1'b0} + ((r == 16'd2) ? 16'd1 : 16'd0);
   endfunction

endpackage

// ===== src/rsc_front.sv =====
// Front end: takes requests, forms the RTT and registers the item for the queue.
// Depends on rsc_pkg.
module rsc_front
   import rsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  logic [TIME_W-1:0]   req_send_time,
   input  logic [TIME_W-1:0]   req_ack_time,
   output logic                push_valid,
   input  logic                push_ready,
   output rsc_item_type        push_item
);

   logic         valid_ff;
   logic         valid_in;
   rsc_item_type item_ff;
   logic         take;

   assign req_ready = !valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // RTT wraps modulo 2^32; ignored downstream on timeouts
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.mode <= req_mode;
         item_ff.rtt  <= req_ack_time - req_send_time;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// ===== src/rsc_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on rsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rsc_queue
   import rsc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  rsc_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output rsc_item_type pop_item
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   rsc_item_type      slot_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_QW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill count must agree
   `ASSERT_IMPLIES(a_queue_ptrs, clock, reset, count_ff == '0 || count_ff == CNT_QW'(DEPTH), wr_ptr_ff == rd_ptr_ff)

endmodule

// ===== src/rsc_back.sv =====
// Back end: sequencer for window updates and RTT statistics (divider, shared multiplier).
// Depends on rsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rsc_back
   import rsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  rsc_item_type        pop_item,
   input  rsc_wload_type       wload,
   input  logic [TIME_W-1:0]   rtt_threshold,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WIN_W-1:0]    rsp_window,
   output logic [MEAN_W-1:0]   rsp_mean_rtt
);

   rsc_state_type state_ff, state_in;

   // architectural state
   logic [WIN_W-1:0]   window_ff;
   logic [WIN_W-1:0]   since_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [MEAN_W-1:0]  mean_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic               rsp_valid_ff;
   logic               pv_ff;
   logic [STEP_W-1:0]  step_ff;

   // per-item working registers
   logic [MEAN_W-1:0]   x_ff;
   logic                ge_ff;
   logic                gt_ff;
   logic [MEAN_W-1:0]   d_old_ff;
   logic [MEAN_W-1:0]   d_new_ff;
   logic [MEAN_W-1:0]   quo_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [MUL_P_W-1:0]  prod_ff;
   logic [1:0]          k_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [SQPROD_W-1:0] p_ff;
   logic [WIN_W-1:0]    rsp_window_ff;
   logic [MEAN_W-1:0]   rsp_mean_ff;

   logic                pop;
   logic                rsp_load;
   logic                in_mul;
   logic                issue;
   logic [1:0]          part;
   logic [MEAN_W-1:0]   x_in;
   logic                ge_in;
   logic [MEAN_W-1:0]   diff_in;
   logic [CNT_W:0]      rem_sh;
   logic                sub_ok;
   logic [CNT_W:0]      rem_sub;
   logic [MEAN_W-1:0]   new_mean;
   logic [CHUNK_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [1:0]          k_in;
   logic [ACC_W-1:0]    prod_sh;
   logic [SQ_W:0]       sq_sum;
   logic                sq_sat;
   logic                grow_ok;
   logic                thr_hit;
   logic                adjust;
   logic [WIN_W-1:0]    window_adj;

   assign pop       = pop_valid && (state_ff == ST_IDLE);
   assign pop_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);
   assign in_mul    = (state_ff == ST_MULA) || (state_ff == ST_MULB) || (state_ff == ST_MULC);
   assign issue     = in_mul && (step_ff < STEP_W'(MUL_PARTS));
   assign part      = step_ff[1:0];

   // entry: sample x = RTT << 8 and |x - mean|
   assign x_in    = {pop_item.rtt, {FRAC_W{1'b0}}};
   assign ge_in   = (x_in >= mean_ff);
   assign diff_in = ge_in ? (x_in - mean_ff) : (mean_ff - x_in);

   // restoring divide, one quotient bit per step
   assign rem_sh  = {rem_ff, quo_ff[MEAN_W-1]};
   assign sub_ok  = (rem_sh >= {1'b0, count_ff});
   assign rem_sub = rem_sh - {1'b0, count_ff};

   assign new_mean = ge_ff ? (mean_ff + quo_ff) : (mean_ff - quo_ff);

   // shared 20x32 multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      k_in  = '0;
      unique case (state_ff)
         ST_MULA: begin
            mul_a = part[1] ? d_old_ff[2*CHUNK_W-1:CHUNK_W] : d_old_ff[CHUNK_W-1:0];
            mul_b = {12'd0, part[0] ? d_new_ff[2*CHUNK_W-1:CHUNK_W] : d_new_ff[CHUNK_W-1:0]};
            k_in  = {1'b0, part[1]} + {1'b0, part[0]};
         end
         ST_MULB: begin
            mul_a = part[1] ? d_new_ff[2*CHUNK_W-1:CHUNK_W] : d_new_ff[CHUNK_W-1:0];
            mul_b = {12'd0, part[0] ? d_new_ff[2*CHUNK_W-1:CHUNK_W] : d_new_ff[CHUNK_W-1:0]};
            k_in  = {1'b0, part[1]} + {1'b0, part[0]};
         end
         ST_MULC: begin
            case (part)
               2'd0:    mul_a = p_ff[CHUNK_W-1:0];
               2'd1:    mul_a = p_ff[2*CHUNK_W-1:CHUNK_W];
               2'd2:    mul_a = p_ff[3*CHUNK_W-1:2*CHUNK_W];
               default: mul_a = p_ff[4*CHUNK_W-1:3*CHUNK_W];
            endcase
            mul_b = count_ff;
            k_in  = part;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      case (k_ff)
         2'd0:    prod_sh = {60'd0, prod_ff};
         2'd1:    prod_sh = {40'd0, prod_ff, 20'd0};
         2'd2:    prod_sh = {20'd0, prod_ff, 40'd0};
         default: prod_sh = {prod_ff, 60'd0};
      endcase
   end

   // saturating sum of squared deviations
   assign sq_sum = {1'b0, sq_ff} + {1'b0, acc_ff[SQ_W-1:0]};
   assign sq_sat = (|acc_ff[SQPROD_W-1:SQ_W]) || sq_sum[SQ_W];

   // n*(x-mean)^2 <= 4*M2, or x not above the mean
   assign grow_ok    = !gt_ff || (acc_ff <= {46'd0, sq_ff, 2'b00});
   assign thr_hit    = (x_ff[MEAN_W-1:FRAC_W] >= rtt_threshold);
   assign adjust     = (since_ff >= window_ff);

   always_comb begin
      window_adj = window_ff;
      if (thr_hit) begin
         window_adj = two_thirds(window_ff);
      end else if (grow_ok && (window_ff != WINDOW_MAX)) begin
         window_adj = window_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = (pop_item.mode == MODE_TIMEOUT) ? ST_FIN : ST_DIV;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(MEAN_W - 1)) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: state_in = ST_MULA;
         ST_MULA: begin
            if (step_ff == STEP_W'(MUL_PARTS)) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: state_in = gt_ff ? ST_MULB : ST_ADJ;
         ST_MULB: begin
            if (step_ff == STEP_W'(MUL_PARTS)) begin
               state_in = ST_PSAVE;
            end
         end
         ST_PSAVE: state_in = ST_MULC;
         ST_MULC: begin
            if (step_ff == STEP_W'(MUL_PARTS)) begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: state_in = ST_FIN;
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= INIT_WINDOW_RST;
         since_ff     <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         step_ff      <= '0;
      end else begin
         pv_ff <= issue;
         if ((state_ff == ST_DIV && step_ff != STEP_W'(MEAN_W - 1)) ||
             (in_mul && step_ff != STEP_W'(MUL_PARTS))) begin
            step_ff <= step_ff + 1'b1;
         end else begin
            step_ff <= '0;
         end
         if (pop) begin
            if (pop_item.mode == MODE_TIMEOUT) begin
               window_ff <= div3(window_ff);
            end else if (count_ff != COUNT_MAX) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (state_ff == ST_MEAN) begin
            mean_ff <= new_mean;
         end
         if (state_ff == ST_SQ) begin
            sq_ff <= sq_sat ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
         end
         if (state_ff == ST_ADJ) begin
            if (adjust) begin
               window_ff <= window_adj;
               since_ff  <= '0;
            end else begin
               since_ff <= since_ff + 1'b1;
            end
         end
         if (wload.en) begin
            window_ff <= wload.value;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (pop) begin
         x_ff     <= x_in;
         ge_ff    <= ge_in;
         d_old_ff <= diff_in;
         quo_ff   <= diff_in;
         rem_ff   <= '0;
      end
      if (state_ff == ST_DIV) begin
         quo_ff <= {quo_ff[MEAN_W-2:0], sub_ok};
         rem_ff <= sub_ok ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      end
      if (state_ff == ST_MEAN) begin
         d_new_ff <= (x_ff >= new_mean) ? (x_ff - new_mean) : (new_mean - x_ff);
         gt_ff    <= (x_ff > new_mean);
      end
      if (issue) begin
         prod_ff <= {32'd0, mul_a} * {20'd0, mul_b};
         k_ff    <= k_in;
      end
      if (pv_ff) begin
         acc_ff <= acc_ff + prod_sh;
      end else if (pop || state_ff == ST_SQ || state_ff == ST_PSAVE) begin
         acc_ff <= '0;
      end
      if (state_ff == ST_PSAVE) begin
         p_ff <= acc_ff[SQPROD_W-1:0];
      end
      if (rsp_load) begin
         rsp_window_ff <= window_ff;
         rsp_mean_ff   <= mean_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_window   = rsp_window_ff;
   assign rsp_mean_rtt = rsp_mean_ff;

   // divider remainder stays below the ack count
   `ASSERT_IMPLIES(a_rem_below_n, clock, reset, state_ff == ST_DIV, rem_ff < count_ff)
   // products fully accumulated before the square sum is used
   `ASSERT_IMPLIES(a_acc_drained, clock, reset, state_ff == ST_SQ || state_ff == ST_ADJ, !pv_ff)
   // the mean moves only in its update step
   `ASSERT_NEXT(a_mean_hold, clock, reset, state_ff != ST_MEAN, $stable(mean_ff))

endmodule

// ===== src/rtt_stat_congestion_window_top.sv =====
// An ack request passes the 40-step restoring divider plus up to three 4-part passes of one
//   20x32 multiplier; the second and third run only when the growth test needs n*(x-mean)^2.
// The back end takes the next item only after it has loaded the response for the last one.
// Timeouts skip the divider and multiplier. A 2-deep queue lets the front keep accepting.
// Reset (synchronous, active high): window 10, threshold 130 ms, statistics cleared.
// Depends on rsc_pkg, rsc_front, rsc_queue, rsc_back.
module rtt_stat_congestion_window_top
   import rsc_pkg::*;
#(
   parameter int QUEUE_ENTRIES = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [TIME_W-1:0]     req_send_time,
   input  logic [TIME_W-1:0]     req_ack_time,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WIN_W-1:0]      rsp_window,
   output logic [MEAN_W-1:0]     rsp_mean_rtt,
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TIME_W-1:0] rtt_thr_ff;
   rsc_wload_type     wload;

   logic              fq_valid, fq_ready;
   rsc_item_type      fq_item;
   logic              qb_valid, qb_ready;
   rsc_item_type      qb_item;

   // Threshold register; initial_window writes go straight into the window.
   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_thr_ff <= RTT_THRESH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RTT_THRESHOLD: rtt_thr_ff <= csr_wdata;
            default: begin
               // initial_window handled by the back end; other indexes ignored
               rtt_thr_ff <= rtt_thr_ff;
            end
         endcase
      end
   end

   assign wload.en    = csr_wr_en && (csr_index == CSR_INITIAL_WINDOW);
   assign wload.value = csr_wdata[WIN_W-1:0];

   // Front: request register, RTT subtract.
   rsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_send_time (req_send_time),
      .req_ack_time  (req_ack_time),
      .push_valid    (fq_valid),
      .push_ready    (fq_ready),
      .push_item     (fq_item)
   );

   // Queue decouples front from the long-running back end.
   rsc_queue #(
      .DEPTH (QUEUE_ENTRIES)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   // Back: Welford update, growth test, window adjust, response register.
   rsc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (qb_valid),
      .pop_ready     (qb_ready),
      .pop_item      (qb_item),
      .wload         (wload),
      .rtt_threshold (rtt_thr_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_window    (rsp_window),
      .rsp_mean_rtt  (rsp_mean_rtt)
   );

endmodule

// ===== bench/tb_rtt_stat_congestion_window_top.sv =====
// Testbench for rtt_stat_congestion_window_top: window control and RTT statistics.
// Self-checking against an in-bench predictor; needs rsc_pkg and the block's RTL only.
module tb_rtt_stat_congestion_window_top;
   import rsc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // indexes that decode to no register
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int LONG_HOLD    = 300;  // receiver hold-off, in cycles
   localparam int SETTLE       = 70;   // a bit over the worst ack latency
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS  = 68;

   typedef struct packed {
      logic              mode;
      logic [TIME_W-1:0] send_time;
      logic [TIME_W-1:0] ack_time;
   } cw_event_type;

   typedef struct packed {
      logic [WIN_W-1:0]  window;
      logic [MEAN_W-1:0] mean_rtt;
   } cw_status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_mode = MODE_ACK;
   logic [TIME_W-1:0]     req_send_time = '0;
   logic [TIME_W-1:0]     req_ack_time = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WIN_W-1:0]      rsp_window;
   logic [MEAN_W-1:0]     rsp_mean_rtt;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rtt_stat_congestion_window_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_send_time (req_send_time),
      .req_ack_time  (req_ack_time),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_window    (rsp_window),
      .rsp_mean_rtt  (rsp_mean_rtt),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ------------------------------------------------------------------
   // Predicted block state and configuration
   // ------------------------------------------------------------------
   logic [WIN_W-1:0]  cfg_init_window = INIT_WINDOW_RST;
   logic [TIME_W-1:0] cfg_threshold   = RTT_THRESH_RST;
   logic [WIN_W-1:0]  cw_window       = INIT_WINDOW_RST;
   logic [WIN_W-1:0]  cw_since_adjust = '0;
   logic [MEAN_W-1:0] cw_mean         = '0;
   logic [SQ_W-1:0]   cw_sq_dev       = '0;
   logic [CNT_W-1:0]  cw_acks         = '0;

   cw_event_type  event_backlog[$];   // requests waiting for the driver
   cw_status_type awaited_status[$];  // predicted responses, oldest first

   bit idle_on      = 1'b0;  // random idle bursts on both channels
   bit holdoff_go   = 1'b0;  // kicks off the long receiver hold
   bit rsp_holdoff  = 1'b0;
   int mismatches   = 0;
   int send_gap     = 0;
   int recv_gap     = 0;
   cw_event_type cur_req;

   // Advance the predicted state by one request; returns the response it yields.
   function automatic cw_status_type apply_event(input cw_event_type ev);
      logic [TIME_W-1:0] rtt;
      logic [63:0]       x, n, old_m, new_m, d_old, d_new, d;
      logic [127:0]      sum, lhs, rhs;
      logic [31:0]       scaled;
      logic              grow_ok;
      cw_status_type     st;
      if (ev.mode == MODE_TIMEOUT) begin
         cw_window = cw_window / 16'd3;
      end else begin
         rtt = ev.ack_time - ev.send_time;   // wraps mod 2^32
         x = {24'd0, rtt, 8'd0};
         if (cw_acks != COUNT_MAX)
            cw_acks = cw_acks + 1'b1;
         n = {32'd0, cw_acks};
         old_m = {24'd0, cw_mean};
         // Welford mean step, quotient truncated toward zero
         if (x >= old_m)
            new_m = old_m + (x - old_m) / n;
         else
            new_m = old_m - (old_m - x) / n;
         cw_mean = new_m[MEAN_W-1:0];
         d_old = (x >= old_m) ? x - old_m : old_m - x;
         d_new = (x >= new_m) ? x - new_m : new_m - x;
         sum = {64'd0, cw_sq_dev} + {64'd0, d_old} * {64'd0, d_new};
         cw_sq_dev = (sum[127:64] != 0) ? '1 : sum[63:0];
         // within mean + 2 sd  <=>  n*(x-mean)^2 <= 4*M2
         if (x <= new_m) begin
            grow_ok = 1'b1;
         end else begin
            d = x - new_m;
            lhs = {64'd0, d} * {64'd0, d} * {64'd0, n};
            rhs = {62'd0, cw_sq_dev, 2'b00};
            grow_ok = (lhs <= rhs);
         end
         if (cw_since_adjust >= cw_window) begin
            if (rtt >= cfg_threshold) begin
               scaled = ({16'd0, cw_window} * 32'd2) / 32'd3;
               cw_window = scaled[WIN_W-1:0];
            end else if (grow_ok && cw_window != WINDOW_MAX) begin
               cw_window = cw_window + 1'b1;
            end
            cw_since_adjust = '0;
         end else begin
            cw_since_adjust = cw_since_adjust + 1'b1;
         end
      end
      st.window   = cw_window;
      st.mean_rtt = cw_mean;
      return st;
   endfunction

   task automatic note_mismatch(input string what, input logic [MEAN_W-1:0] exp_v,
                                input logic [MEAN_W-1:0] act_v);
      if (mismatches < 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Request driver: pops the backlog, holds payload until accepted,
   // and inserts random idle bursts when idle_on is set.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            awaited_status.push_back(apply_event(cur_req));
         if (req_valid && !req_ready) begin
            // still waiting on the handshake: hold everything
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(0, 17);
            req_valid <= 1'b0;
         end else if (event_backlog.size() != 0) begin
            cur_req = event_backlog.pop_front();
            req_mode      <= cur_req.mode;
            req_send_time <= cur_req.send_time;
            req_ack_time  <= cur_req.ack_time;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: checks each accepted response against the oldest
   // prediction and throttles rsp_ready.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cw_status_type exp_st;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_status.size() == 0) begin
               note_mismatch("unexpected response, window", '0, MEAN_W'(rsp_window));
            end else begin
               exp_st = awaited_status.pop_front();
               if (rsp_window !== exp_st.window)
                  note_mismatch("window", MEAN_W'(exp_st.window), MEAN_W'(rsp_window));
               if (rsp_mean_rtt !== exp_st.mean_rtt)
                  note_mismatch("mean_rtt", exp_st.mean_rtt, rsp_mean_rtt);
            end
         end
         if (rsp_holdoff) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            recv_gap <= $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off so the block backs up and drops req_ready.
   initial begin
      wait (holdoff_go);
      @(negedge clock);
      rsp_holdoff = 1'b1;
      repeat (LONG_HOLD) @(negedge clock);
      rsp_holdoff = 1'b0;
   end

   // Register write; only called while the block is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_INITIAL_WINDOW: begin
            cfg_init_window = data[WIN_W-1:0];
            cw_window       = data[WIN_W-1:0];   // loads the live window too
         end
         CSR_RTT_THRESHOLD: cfg_threshold = data;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic push_ack(input logic [TIME_W-1:0] send_t, input logic [TIME_W-1:0] rtt);
      event_backlog.push_back('{MODE_ACK, send_t, send_t + rtt});
   endtask

   task automatic push_timeout(input logic [TIME_W-1:0] send_t,
                               input logic [TIME_W-1:0] ack_t);
      event_backlog.push_back('{MODE_TIMEOUT, send_t, ack_t});
   endtask

   // Wait until every request is out and every response is back.
   task automatic drain();
      while (event_backlog.size() != 0 || req_valid || awaited_status.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Mostly a steady RTT near 100 ms, some spikes past the threshold and
   // some broad values; send times are random so both stamps wrap.
   task automatic push_random();
      logic [TIME_W-1:0] rtt;
      if ($urandom_range(0, 9) == 0) begin
         push_timeout($urandom, $urandom);
      end else begin
         case ($urandom_range(0, 9))
            0:       rtt = $urandom_range(0, 400);
            1:       rtt = 100 + $urandom_range(30, 120);
            default: rtt = 97 + $urandom_range(0, 6);
         endcase
         push_ack($urandom, rtt);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [WIN_W-1:0]  win;
      logic [TIME_W-1:0] thr;
      int                half;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset config first, then zero window, wrap of the
      // timestamps, timeouts at both window extremes, threshold extremes.
      push_ack(32'd0, 32'd100);
      drain();
      write_csr(CSR_INITIAL_WINDOW, 32'd0);
      push_ack(32'hFFFF_FFFF, 32'd100);       // ack stamp wraps through zero
      push_ack($urandom, 32'd100);
      push_ack($urandom, 32'd200);            // at/over threshold: shrink
      push_ack($urandom, 32'd100);
      push_ack($urandom, 32'd100);
      push_timeout(32'd0, 32'd0);
      push_timeout(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      write_csr(CSR_INITIAL_WINDOW, 32'hFFFF_FFFF);  // upper data bits dropped
      push_timeout($urandom, $urandom);
      push_timeout($urandom, $urandom);
      push_ack(32'hFFFF_FFFF, 32'd0);          // zero RTT
      push_timeout($urandom, $urandom);
      drain();
      write_csr(CSR_INITIAL_WINDOW, 32'd2);
      write_csr(CSR_RTT_THRESHOLD, 32'd0);     // every adjustment shrinks
      push_ack(32'hFFFF_FF9B, 32'd100);
      push_ack($urandom, 32'd0);
      push_ack($urandom, 32'd130);
      push_ack($urandom, 32'd90);
      drain();
      write_csr(CSR_RTT_THRESHOLD, 32'hFFFF_FFFF);   // never shrinks
      write_csr(CSR_SPARE_2, $urandom);
      write_csr(CSR_SPARE_3, $urandom);
      push_ack($urandom, 32'd100);
      push_ack($urandom, 32'd101);
      push_ack($urandom, 32'd99);
      push_ack($urandom, 32'd100);
      drain();
      write_csr(CSR_RTT_THRESHOLD, 32'd130);
      push_ack($urandom, 32'd129);
      push_ack($urandom, 32'd130);              // exactly at threshold
      drain();

      // Random phases, each with its own window and threshold setting.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         idle_on = (ph != 3) && (ph < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0:       win = 16'd0;
            1:       win = 16'd1;
            2:       win = 16'd2;
            3:       win = WINDOW_MAX;
            4:       win = $urandom;
            default: win = $urandom_range(3, 24);
         endcase
         case ($urandom_range(0, 5))
            0:       thr = 32'd0;
            1:       thr = 32'hFFFF_FFFF;
            2:       thr = $urandom;
            3:       thr = 32'd130;
            default: thr = $urandom_range(95, 140);
         endcase
         write_csr(CSR_INITIAL_WINDOW, {16'($urandom), win});
         write_csr(CSR_RTT_THRESHOLD, thr);
         if (ph == 3) begin
            // back-pressure: sender keeps offering while the receiver holds off
            for (int k = 0; k < PHASE_ITEMS; k++)
               push_random();
            holdoff_go = 1'b1;
         end else if (ph == 6) begin
            // sender pauses mid-phase until everything has come back
            half = PHASE_ITEMS / 2;
            for (int k = 0; k < half; k++)
               push_random();
            drain();
            for (int k = half; k < PHASE_ITEMS; k++)
               push_random();
         end else begin
            for (int k = 0; k < PHASE_ITEMS; k++)
               push_random();
         end
         drain();
      end

      // Tail, no idling: RTT at the threshold's maximum, then a full-scale
      // swing that pins the deviation sum at its ceiling.
      idle_on = 1'b0;
      write_csr(CSR_INITIAL_WINDOW, 32'd0);
      write_csr(CSR_RTT_THRESHOLD, 32'hFFFF_FFFF);
      push_ack($urandom, 32'hFFFF_FFFF);
      push_ack($urandom, 32'd0);
      push_ack($urandom, 32'h8000_0000);
      push_ack($urandom, 32'd100);
      push_timeout($urandom, $urandom);
      push_ack($urandom, 32'd5);
      drain();

      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && awaited_status.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
